// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the checker files.
// Each macro samples on the rising edge of clk and is held off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every sampled edge.
`define CHK_HOLDS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// When trig is seen, res must hold at the next sampled edge.
`define CHK_NEXT(label, trig, res, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (res)) \
    else $error(msg);

`endif

// ===== rtl/rv32x_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package rv32x_pkg;

  // Major opcodes
  localparam logic [6:0] OP_REG    = 7'h33;
  localparam logic [6:0] OP_IMM    = 7'h13;
  localparam logic [6:0] OP_LOAD   = 7'h03;
  localparam logic [6:0] OP_JALR   = 7'h67;
  localparam logic [6:0] OP_SYSTEM = 7'h73;
  localparam logic [6:0] OP_STORE  = 7'h23;
  localparam logic [6:0] OP_BRANCH = 7'h63;
  localparam logic [6:0] OP_AUIPC  = 7'h17;
  localparam logic [6:0] OP_LUI    = 7'h37;
  localparam logic [6:0] OP_JAL    = 7'h6f;

  // funct7
  localparam logic [6:0] F7_BASE   = 7'h00;
  localparam logic [6:0] F7_ALT    = 7'h20;
  localparam logic [6:0] F7_MULDIV = 7'h01;

  // funct3, ALU
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // funct3, M extension subset
  localparam logic [2:0] F3_MUL  = 3'd0;
  localparam logic [2:0] F3_MULH = 3'd1;
  localparam logic [2:0] F3_DIV  = 3'd4;
  localparam logic [2:0] F3_REM  = 3'd6;

  // funct3, branches
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // funct3, loads and stores
  localparam logic [2:0] F3_LB   = 3'd0;
  localparam logic [2:0] F3_LH   = 3'd1;
  localparam logic [2:0] F3_LW   = 3'd2;
  localparam logic [2:0] F3_LBU  = 3'd4;
  localparam logic [2:0] F3_LHU  = 3'd5;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ILLEGAL = 3'd1;
  localparam logic [2:0] ST_BADMEM  = 3'd2;
  localparam logic [2:0] ST_ECALL   = 3'd3;
  localparam logic [2:0] ST_EXIT    = 3'd4;

  // Environment call
  localparam logic [31:0] ECALL_WORD     = 32'h0000_0073;
  localparam logic [31:0] SVC_PRINT_INT  = 32'd1;
  localparam logic [31:0] SVC_PRINT_STR  = 32'd4;
  localparam logic [31:0] SVC_EXIT       = 32'd10;
  localparam logic [31:0] SVC_PRINT_CHAR = 32'd11;

  localparam logic [31:0] ALL_ONES = 32'hffff_ffff;

  localparam logic [4:0] REG_A0 = 5'd10;
  localparam logic [4:0] REG_A1 = 5'd11;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [31:0] remainder;
  } div_rsp_t;

  // Shared integer ALU: add/sub, shifts, compares, logic.
  function automatic logic [31:0] alu_calc(input logic [2:0] f3, input logic alt,
                                           input logic [31:0] a, input logic [31:0] b);
    logic [4:0]  sh;
    logic [31:0] r;
    sh = b[4:0];
    case (f3)
      F3_ADD:  r = alt ? (a - b) : (a + b);
      F3_SLL:  r = a << sh;
      F3_SLT:  r = {31'd0, ($signed(a) < $signed(b))};
      F3_SLTU: r = {31'd0, (a < b)};
      F3_XOR:  r = a ^ b;
      F3_SR:   r = alt ? 32'($signed(a) >>> sh) : (a >> sh);
      F3_OR:   r = a | b;
      default: r = a & b;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/rv32x_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Signed 32-bit divider, one quotient bit per cycle on magnitudes.
module rv32x_div
  import rv32x_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [31:0] rem;
  logic [31:0] quo;
  logic [31:0] ub;
  logic [31:0] a_raw;
  logic        qneg;
  logic        rneg;
  logic        zero_div;

  logic [32:0] tmp;
  logic [32:0] diff;
  logic        ge;

  assign tmp  = {rem, quo[31]};
  assign diff = tmp - {1'b0, ub};
  assign ge   = !diff[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd32;
      end else if (busy) begin
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem      <= '0;
      quo      <= req.dividend[31] ? (32'd0 - req.dividend) : req.dividend;
      ub       <= req.divisor[31] ? (32'd0 - req.divisor) : req.divisor;
      a_raw    <= req.dividend;
      qneg     <= req.dividend[31] ^ req.divisor[31];
      rneg     <= req.dividend[31];
      zero_div <= (req.divisor == 32'd0);
    end else if (busy) begin
      rem <= ge ? diff[31:0] : tmp[31:0];
      quo <= {quo[30:0], ge};
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = zero_div ? ALL_ONES : (qneg ? (32'd0 - quo) : quo);
  assign rsp.remainder = zero_div ? a_raw : (rneg ? (32'd0 - rem) : rem);

endmodule

`default_nettype wire

// ===== rtl/rv32im_instruction_execute.sv =====
`timescale 1ns / 1ps
`default_nettype none

// RV32IM instruction executor.
// Input stream: s_tdata carries one 32-bit instruction word per transfer; it is
// executed at the current PC against the internal register file and a
// MEM_BYTES byte data memory (little-endian, misaligned access allowed).
// Output stream: one transfer per instruction; m_tdata holds pc_after,
// call_service and call_argument, m_tuser holds the status code.
// Each instruction passes S_EXEC and then S_DONE, which loads the output
// register; MUL/MULH also pass S_MUL, DIV/REM wait in S_DIV while the
// shared divider retires one quotient bit a cycle, and loads and stores
// move one byte a cycle on the single memory port in S_LD or S_ST. A
// faulting load or store goes straight to S_DONE; halted ones skip S_EXEC.
// s_tready is high only while no instruction is in work, that is in S_IDLE,
// which the block enters in the same cycle that the result is registered.
// Reset: the register file reads zero at once, PC and halt flag clear, then a
// clearing pass zeroes every data memory byte with s_tready low.
// A stalled receiver holds the result in the output register; the next
// instruction is taken meanwhile but waits before committing its result.
// After an error or the exit call every instruction reports status 4.
module rv32im_instruction_execute
  import rv32x_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] instruction_word
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [95:0] m_tdata,   // [31:0] pc_after, [63:32] call_service,
                                 // [95:64] call_argument
  output logic [2:0]  m_tuser    // [2:0] status
);

  localparam int AW = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(MEM_BYTES - 1);
  localparam logic [32:0]   MEM_LIMIT = 33'(MEM_BYTES);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_EXEC  = 8'b0000_0100,
    S_MUL   = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_LD    = 8'b0010_0000,
    S_ST    = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  state_t state;
  state_t ex_state;

  // Architectural state
  logic [31:0] pc;
  logic        halted;
  logic [31:0] rf [32];
  logic [31:0] rf_valid;
  logic [7:0]  mem [MEM_BYTES];

  // Per-instruction registers
  logic [31:0] instr_q;
  logic [31:0] a_q;
  logic [31:0] b_q;
  logic [2:0]  status_q;
  logic [31:0] next_q;
  logic [31:0] svc_q;
  logic [31:0] arg_q;
  logic [31:0] addr_q;
  logic [2:0]  size_q;
  logic [2:0]  cnt;
  logic [31:0] ld_data;
  logic [63:0] prod;
  logic [AW-1:0] clr_cnt;
  logic [7:0]  mem_rdata;

  logic        accept;
  logic [4:0]  rs1;
  logic [4:0]  rs2;

  // Decode fields
  logic [6:0]  op;
  logic [4:0]  rd;
  logic [2:0]  f3;
  logic [6:0]  f7;
  logic [31:0] imm_i;
  logic [31:0] imm_s;
  logic [31:0] imm_b;
  logic [31:0] imm_j;
  logic [31:0] upper;
  logic [31:0] alu_b;
  logic        alu_alt;
  logic [31:0] alu_res;
  logic [31:0] mem_off;
  logic [31:0] ex_addr;
  logic [2:0]  ex_size;
  logic        ex_inb;

  // Execute decisions
  logic [2:0]  ex_status;
  logic [31:0] ex_next;
  logic [31:0] ex_svc;
  logic [31:0] ex_arg;
  logic        ex_wr;
  logic [31:0] ex_wval;
  logic        ex_div;
  logic        take;

  // Write ports
  logic        rf_we;
  logic [31:0] rf_wdata;
  logic        mem_we;
  logic        mem_re;
  logic [AW-1:0] mem_idx;
  logic [7:0]  mem_wdata;
  logic [1:0]  lane;
  logic [31:0] ld_full;
  logic [31:0] ld_ext;
  logic        out_free;
  logic [31:0] pc_new;

  div_req_t    div_req;
  div_rsp_t    div_rsp;

  rv32x_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // ECALL reads a0/a1 through the same two read ports
  assign rs1 = (s_tdata[6:0] == OP_SYSTEM) ? REG_A0 : s_tdata[19:15];
  assign rs2 = (s_tdata[6:0] == OP_SYSTEM) ? REG_A1 : s_tdata[24:20];

  assign op    = instr_q[6:0];
  assign rd    = instr_q[11:7];
  assign f3    = instr_q[14:12];
  assign f7    = instr_q[31:25];
  assign imm_i = {{20{instr_q[31]}}, instr_q[31:20]};
  assign imm_s = {{20{instr_q[31]}}, instr_q[31:25], instr_q[11:7]};
  assign imm_b = {{19{instr_q[31]}}, instr_q[31], instr_q[7], instr_q[30:25],
                  instr_q[11:8], 1'b0};
  assign imm_j = {{11{instr_q[31]}}, instr_q[31], instr_q[19:12], instr_q[20],
                  instr_q[30:21], 1'b0};
  assign upper = {instr_q[31:12], 12'd0};

  // Shift immediates use the shamt field; other immediates sign-extend
  assign alu_b   = (op != OP_IMM) ? b_q :
                   ((f3 == F3_SLL || f3 == F3_SR) ? {27'd0, instr_q[24:20]} : imm_i);
  assign alu_alt = (op == OP_REG) ? (f7 == F7_ALT) : ((f3 == F3_SR) && (f7 == F7_ALT));
  assign alu_res = alu_calc(f3, alu_alt, a_q, alu_b);

  assign mem_off = (op == OP_STORE) ? imm_s : imm_i;
  assign ex_addr = a_q + mem_off;
  assign ex_size = 3'd1 << f3[1:0];
  assign ex_inb  = ({1'b0, ex_addr} + {30'd0, ex_size}) <= MEM_LIMIT;

  always_comb begin
    ex_state  = S_DONE;
    ex_status = ST_OK;
    ex_next   = pc + 32'd4;
    ex_svc    = '0;
    ex_arg    = '0;
    ex_wr     = 1'b0;
    ex_wval   = alu_res;
    ex_div    = 1'b0;
    take      = 1'b0;
    unique case (op)
      OP_REG: begin
        if (f7 == F7_BASE || (f7 == F7_ALT && (f3 == F3_ADD || f3 == F3_SR))) begin
          ex_wr = 1'b1;
        end else if (f7 == F7_MULDIV && (f3 == F3_MUL || f3 == F3_MULH)) begin
          ex_state = S_MUL;
        end else if (f7 == F7_MULDIV && (f3 == F3_DIV || f3 == F3_REM)) begin
          ex_state = S_DIV;
          ex_div   = 1'b1;
        end else begin
          ex_status = ST_ILLEGAL;
        end
      end
      OP_IMM: begin
        if ((f3 == F3_SLL && f7 != F7_BASE) ||
            (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT)) begin
          ex_status = ST_ILLEGAL;
        end else begin
          ex_wr = 1'b1;
        end
      end
      OP_LOAD: begin
        if (!(f3 == F3_LB || f3 == F3_LH || f3 == F3_LW || f3 == F3_LBU ||
              f3 == F3_LHU)) begin
          ex_status = ST_ILLEGAL;
        end else if (!ex_inb) begin
          ex_status = ST_BADMEM;
        end else begin
          ex_state = S_LD;
        end
      end
      OP_STORE: begin
        if (f3 > F3_LW) begin
          ex_status = ST_ILLEGAL;
        end else if (!ex_inb) begin
          ex_status = ST_BADMEM;
        end else begin
          ex_state = S_ST;
        end
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (a_q == b_q);
          F3_BNE:  take = (a_q != b_q);
          F3_BLT:  take = ($signed(a_q) < $signed(b_q));
          F3_BGE:  take = !($signed(a_q) < $signed(b_q));
          F3_BLTU: take = (a_q < b_q);
          F3_BGEU: take = (a_q >= b_q);
          default: ex_status = ST_ILLEGAL;
        endcase
        if (take) begin
          ex_next = pc + imm_b;
        end
      end
      OP_JAL: begin
        ex_wr   = 1'b1;
        ex_wval = pc + 32'd4;
        ex_next = pc + imm_j;
      end
      OP_JALR: begin
        if (f3 != 3'd0) begin
          ex_status = ST_ILLEGAL;
        end else begin
          ex_wr   = 1'b1;
          ex_wval = pc + 32'd4;
          ex_next = {ex_addr[31:1], 1'b0};
        end
      end
      OP_LUI: begin
        ex_wr   = 1'b1;
        ex_wval = upper;
      end
      OP_AUIPC: begin
        ex_wr   = 1'b1;
        ex_wval = pc + upper;
      end
      OP_SYSTEM: begin
        if (instr_q != ECALL_WORD) begin
          ex_status = ST_ILLEGAL;
        end else if (a_q == SVC_EXIT) begin
          ex_status = ST_EXIT;
          ex_svc    = a_q;
        end else if (a_q == SVC_PRINT_INT || a_q == SVC_PRINT_STR ||
                     a_q == SVC_PRINT_CHAR) begin
          ex_status = ST_ECALL;
          ex_svc    = a_q;
          ex_arg    = b_q;
        end else begin
          ex_status = ST_ILLEGAL;
        end
      end
      default: ex_status = ST_ILLEGAL;
    endcase
  end

  assign div_req.start    = (state == S_EXEC) && ex_div;
  assign div_req.dividend = a_q;
  assign div_req.divisor  = b_q;

  // Load assembly: the byte read last cycle lands in lane cnt-1
  assign lane    = cnt[1:0] - 2'd1;
  assign ld_full = ld_data | ({24'd0, mem_rdata} << {lane, 3'b000});
  always_comb begin
    case (f3)
      F3_LB:   ld_ext = {{24{ld_full[7]}}, ld_full[7:0]};
      F3_LH:   ld_ext = {{16{ld_full[15]}}, ld_full[15:0]};
      default: ld_ext = ld_full;
    endcase
  end

  // Register file write port
  always_comb begin
    rf_we    = 1'b0;
    rf_wdata = ex_wval;
    unique case (state)
      S_EXEC: begin
        rf_we    = ex_wr;
        rf_wdata = ex_wval;
      end
      S_MUL: begin
        rf_we    = 1'b1;
        rf_wdata = (f3 == F3_MULH) ? prod[63:32] : prod[31:0];
      end
      S_DIV: begin
        rf_we    = div_rsp.done;
        rf_wdata = (f3 == F3_REM) ? div_rsp.remainder : div_rsp.quotient;
      end
      S_LD: begin
        rf_we    = (cnt == size_q);
        rf_wdata = ld_ext;
      end
      default: rf_we = 1'b0;
    endcase
  end

  // Data memory port: clearing pass, store bytes or load bytes
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_wdata = '0;
    mem_idx   = addr_q[AW-1:0] + AW'(cnt);
    unique case (state)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_idx = clr_cnt;
      end
      S_ST: begin
        mem_we    = 1'b1;
        mem_wdata = b_q[{cnt[1:0], 3'b000} +: 8];
      end
      S_LD: mem_re = (cnt < size_q);
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_idx] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata <= mem[mem_idx];
    end
  end

  // Register file storage; x0 is never written so it always reads zero
  always_ff @(posedge clk) begin
    if (rf_we && rd != 5'd0) begin
      rf[rd] <= rf_wdata;
    end
    if (accept) begin
      a_q <= rf_valid[rs1] ? rf[rs1] : 32'd0;
      b_q <= rf_valid[rs2] ? rf[rs2] : 32'd0;
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign pc_new   = (status_q == ST_OK || status_q == ST_ECALL) ? next_q : pc;

  // Payload registers
  always_ff @(posedge clk) begin
    prod <= 64'($signed(a_q) * $signed(b_q));
    if (accept) begin
      instr_q <= s_tdata;
      if (halted) begin
        status_q <= ST_EXIT;
        svc_q    <= '0;
        arg_q    <= '0;
      end
    end
    if (state == S_EXEC) begin
      status_q <= ex_status;
      next_q   <= ex_next;
      svc_q    <= ex_svc;
      arg_q    <= ex_arg;
      addr_q   <= ex_addr;
      size_q   <= ex_size;
      ld_data  <= '0;
    end
    if (state == S_LD && cnt != 3'd0) begin
      ld_data <= ld_full;
    end
    if (state == S_DONE && out_free) begin
      m_tdata <= {arg_q, svc_q, pc_new};
      m_tuser <= status_q;
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      clr_cnt  <= '0;
      cnt      <= '0;
      pc       <= '0;
      halted   <= 1'b0;
      rf_valid <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (rf_we && rd != 5'd0) begin
        rf_valid[rd] <= 1'b1;
      end
      // Raise valid with a new result, drop it once the receiver takes it
      if (state == S_DONE && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + AW'(1);
          if (clr_cnt == CLR_LAST) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            state <= halted ? S_DONE : S_EXEC;
          end
        end
        S_EXEC: begin
          cnt   <= '0;
          state <= ex_state;
        end
        S_MUL: state <= S_DONE;
        S_DIV: begin
          if (div_rsp.done) begin
            state <= S_DONE;
          end
        end
        S_LD: begin
          // Issue one byte read a cycle; collect it the cycle after
          if (cnt == size_q) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_ST: begin
          if (cnt == size_q - 3'd1) begin
            state <= S_DONE;
          end else begin
            cnt <= cnt + 3'd1;
          end
        end
        S_DONE: begin
          // Commit the PC and hand the result over once the output is free
          if (out_free) begin
            pc <= pc_new;
            if (!(status_q == ST_OK || status_q == ST_ECALL)) begin
              halted <= 1'b1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/rv32x_chk.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module rv32x_chk
  import rv32x_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [95:0] m_tdata,
  input logic [2:0]  m_tuser
);

  `CHK_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")
  `CHK_HOLDS(a_no_svc, m_tvalid && (m_tuser == ST_OK || m_tuser == ST_ILLEGAL || m_tuser == ST_BADMEM) |-> m_tdata[63:32] == 32'd0, "service value without a call")
  `CHK_HOLDS(a_no_arg, m_tvalid && m_tuser != ST_ECALL |-> m_tdata[95:64] == 32'd0, "argument value without a call")
  `CHK_HOLDS(a_clear_pass, $past(rst) |-> !s_tready, "input taken before memory clear")

endmodule

bind rv32im_instruction_execute rv32x_chk u_chk (.*);

`default_nettype wire

// ===== test/rv32im_exec_checker.sv =====
`timescale 1ns / 1ps

module rv32im_exec_checker
  import rv32x_pkg::*;
#(
  parameter int MEM_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [95:0] m_tdata,
  input  logic [2:0]  m_tuser,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [31:0] pc_after;
    logic [2:0]  status;
    logic [31:0] call_service;
    logic [31:0] call_argument;
  } retire_t;

  retire_t     retire_q[$];
  logic [31:0] gpr[32];
  logic [7:0]  dmem[MEM_BYTES];
  logic [31:0] cur_pc;
  logic        stopped;

  assign pending = retire_q.size();

  function automatic logic [31:0] sx(input logic [31:0] v, input int bits);
    logic [31:0] m;
    m = 32'(1) << (bits - 1);
    v = v & ((m << 1) - 1);
    return (v ^ m) - m;
  endfunction

  function automatic logic [31:0] mag(input logic [31:0] v);
    return v[31] ? -v : v;
  endfunction

  // Returns 0 for an encoding that the block must reject.
  function automatic bit alu_op(input logic [6:0] f7, input logic [2:0] f3,
                                input logic [31:0] a, input logic [31:0] b,
                                output logic [31:0] r);
    logic signed [63:0] prod;
    logic [31:0]        q;
    r = '0;
    if (f7 == F7_BASE) begin
      case (f3)
        F3_ADD:  r = a + b;
        F3_SLL:  r = a << b[4:0];
        F3_SLT:  r = ($signed(a) < $signed(b)) ? 32'd1 : 32'd0;
        F3_SLTU: r = (a < b) ? 32'd1 : 32'd0;
        F3_XOR:  r = a ^ b;
        F3_SR:   r = a >> b[4:0];
        F3_OR:   r = a | b;
        default: r = a & b;
      endcase
      return 1;
    end
    if (f7 == F7_ALT) begin
      if (f3 == F3_ADD) begin
        r = a - b;
        return 1;
      end
      if (f3 == F3_SR) begin
        r = $signed(a) >>> b[4:0];
        return 1;
      end
      return 0;
    end
    if (f7 == F7_MULDIV) begin
      case (f3)
        F3_MUL:  r = a * b;
        F3_MULH: begin
          prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
          r = prod[63:32];
        end
        F3_DIV: begin
          if (b == 0) r = ALL_ONES;
          else if (a == 32'h8000_0000 && b == ALL_ONES) r = 32'h8000_0000;
          else begin
            q = mag(a) / mag(b);
            r = (a[31] ^ b[31]) ? -q : q;
          end
        end
        F3_REM: begin
          if (b == 0) r = a;
          else if (a == 32'h8000_0000 && b == ALL_ONES) r = 0;
          else begin
            q = mag(a) % mag(b);
            r = a[31] ? -q : q;
          end
        end
        default: return 0;
      endcase
      return 1;
    end
    return 0;
  endfunction

  function automatic void put_reg(input logic [4:0] rd, input logic [31:0] v);
    if (rd != 0) gpr[rd] = v;
  endfunction

  function automatic bit fits(input logic [31:0] addr, input int size);
    return ({32'd0, addr} + 64'(size)) <= 64'(MEM_BYTES);
  endfunction

  // Execute one instruction word against the shadow machine state.
  function automatic retire_t execute_word(input logic [31:0] w);
    retire_t     e;
    logic [6:0]  op, f7;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [31:0] a, b, imm_i, imm_s, imm_b, imm_j, nxt, r, addr;
    int          size;
    bit          take;
    e = '0;
    e.pc_after = cur_pc;
    if (stopped) begin
      e.status = ST_EXIT;
      return e;
    end
    op = w[6:0]; rd = w[11:7]; f3 = w[14:12]; f7 = w[31:25];
    a = gpr[w[19:15]]; b = gpr[w[24:20]];
    imm_i = sx(w >> 20, 12);
    imm_s = sx({w[31:25], w[11:7]}, 12);
    imm_b = sx({w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
    imm_j = sx({w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
    nxt = cur_pc + 4;
    e.status = ST_OK;
    take = 0;
    r = 0;
    case (op)
      OP_REG: if (alu_op(f7, f3, a, b, r)) put_reg(rd, r); else e.status = ST_ILLEGAL;
      OP_IMM: begin
        if (f3 == F3_SLL || f3 == F3_SR) begin
          if ((f3 == F3_SLL && f7 != F7_BASE) ||
              (f3 == F3_SR && f7 != F7_BASE && f7 != F7_ALT))
            e.status = ST_ILLEGAL;
          else if (alu_op(f7, f3, a, {27'd0, w[24:20]}, r)) put_reg(rd, r);
          else e.status = ST_ILLEGAL;
        end else if (alu_op(F7_BASE, f3, a, imm_i, r)) put_reg(rd, r);
      end
      OP_LOAD: begin
        if (f3 == 3'd3 || f3 > F3_LHU) e.status = ST_ILLEGAL;
        else begin
          size = 1 << f3[1:0];
          addr = a + imm_i;
          if (!fits(addr, size)) e.status = ST_BADMEM;
          else begin
            for (int i = 0; i < size; i++) r[8*i +: 8] = dmem[addr + i];
            if (f3 == F3_LB) r = sx(r, 8);
            else if (f3 == F3_LH) r = sx(r, 16);
            put_reg(rd, r);
          end
        end
      end
      OP_STORE: begin
        if (f3 > F3_LW) e.status = ST_ILLEGAL;
        else begin
          size = 1 << f3;
          addr = a + imm_s;
          if (!fits(addr, size)) e.status = ST_BADMEM;
          else for (int i = 0; i < size; i++) dmem[addr + i] = b[8*i +: 8];
        end
      end
      OP_BRANCH: begin
        case (f3)
          F3_BEQ:  take = (a == b);
          F3_BNE:  take = (a != b);
          F3_BLT:  take = $signed(a) < $signed(b);
          F3_BGE:  take = !($signed(a) < $signed(b));
          F3_BLTU: take = a < b;
          F3_BGEU: take = a >= b;
          default: e.status = ST_ILLEGAL;
        endcase
        if (take) nxt = cur_pc + imm_b;
      end
      OP_JAL: begin
        put_reg(rd, cur_pc + 4);
        nxt = cur_pc + imm_j;
      end
      OP_JALR: begin
        if (f3 != 0) e.status = ST_ILLEGAL;
        else begin
          nxt = (a + imm_i) & ~32'd1;
          put_reg(rd, cur_pc + 4);
        end
      end
      OP_LUI:   put_reg(rd, {w[31:12], 12'd0});
      OP_AUIPC: put_reg(rd, cur_pc + {w[31:12], 12'd0});
      OP_SYSTEM: begin
        if (w != ECALL_WORD) e.status = ST_ILLEGAL;
        else begin
          e.call_service = gpr[REG_A0];
          if (gpr[REG_A0] == SVC_EXIT) e.status = ST_EXIT;
          else if (gpr[REG_A0] == SVC_PRINT_INT || gpr[REG_A0] == SVC_PRINT_STR ||
                   gpr[REG_A0] == SVC_PRINT_CHAR) begin
            e.status = ST_ECALL;
            e.call_argument = gpr[REG_A1];
          end else begin
            e.status = ST_ILLEGAL;
            e.call_service = 0;
          end
        end
      end
      default: e.status = ST_ILLEGAL;
    endcase
    if (e.status == ST_OK || e.status == ST_ECALL) cur_pc = nxt;
    else stopped = 1;
    e.pc_after = cur_pc;
    return e;
  endfunction

  always @(posedge clk) begin
    retire_t want, got;
    if (rst) begin
      retire_q.delete();
      foreach (gpr[i]) gpr[i] = 0;
      foreach (dmem[i]) dmem[i] = 0;
      cur_pc = 0;
      stopped = 0;
      fail_count = 0;
    end else begin
      // check the outgoing transfer before queuing the incoming one
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tuser, m_tdata[63:32], m_tdata[95:64]};
        if (retire_q.size() == 0) begin
          $display("%0t: unexpected result pc=%h status=%0d", $time,
                   got.pc_after, got.status);
          fail_count++;
        end else begin
          want = retire_q.pop_front();
          if (got.pc_after != want.pc_after) begin
            $display("%0t: pc_after expected %h actual %h", $time,
                     want.pc_after, got.pc_after);
            fail_count++;
          end
          if (got.status != want.status) begin
            $display("%0t: status expected %0d actual %0d", $time,
                     want.status, got.status);
            fail_count++;
          end
          if (got.call_service != want.call_service) begin
            $display("%0t: call_service expected %h actual %h", $time,
                     want.call_service, got.call_service);
            fail_count++;
          end
          if (got.call_argument != want.call_argument) begin
            $display("%0t: call_argument expected %h actual %h", $time,
                     want.call_argument, got.call_argument);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) retire_q.push_back(execute_word(s_tdata));
    end
  end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import rv32x_pkg::*;

  localparam int MEM_BYTES = 4096;
  localparam logic [4:0] BASE_REG = 5'd5;  // fixed data pointer, never overwritten

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // [31:0] instruction_word
  logic        m_tvalid;
  logic        m_tready;
  logic [95:0] m_tdata;   // [31:0] pc_after, [63:32] call_service, [95:64] call_argument
  logic [2:0]  m_tuser;   // [2:0] status
  int          fail_count;
  int          pending;

  int burst_left;
  int stall_mode = 0;
  int stall_run = 0;

  rv32im_instruction_execute #(.MEM_BYTES(MEM_BYTES)) dut (.*);

  rv32im_exec_checker #(.MEM_BYTES(MEM_BYTES)) chk (.*);

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  // Instruction encoders
  function automatic logic [31:0] enc_r(logic [6:0] f7, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3, logic [4:0] rd, logic [6:0] op);
    return {f7, rs2, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] op);
    return {imm, rs1, f3, rd, op};
  endfunction

  function automatic logic [31:0] enc_s(logic [11:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[11:5], rs2, rs1, f3, imm[4:0], OP_STORE};
  endfunction

  function automatic logic [31:0] enc_b(logic [12:0] imm, logic [4:0] rs2, logic [4:0] rs1,
                                        logic [2:0] f3);
    return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OP_BRANCH};
  endfunction

  function automatic logic [31:0] enc_j(logic [20:0] imm, logic [4:0] rd);
    return {imm[20], imm[10:1], imm[11], imm[19:12], rd, OP_JAL};
  endfunction

  // Any destination except the data pointer.
  function automatic logic [4:0] any_rd();
    logic [4:0] r;
    r = 5'($urandom);
    return (r == BASE_REG) ? 5'd6 : r;
  endfunction

  // Source register, biased toward the low registers that hold corner values.
  function automatic logic [4:0] any_rs();
    return ($urandom_range(0, 2) == 0) ? 5'($urandom) : 5'($urandom_range(0, 7));
  endfunction

  // Memory offset that keeps the access in range: x0 reaches the lower half,
  // the data pointer (0x800) reaches the whole memory.
  function automatic logic [11:0] safe_offset(logic [4:0] base);
    if (base == 0) return 12'($urandom_range(0, 2044));
    return 12'(int'($urandom_range(0, 4092)) - 2048);
  endfunction

  // Random legal instruction that never halts the core.
  function automatic logic [31:0] random_legal();
    logic [2:0] f3;
    logic [4:0] base;
    case ($urandom_range(0, 9))
      0, 1: begin
        case ($urandom_range(0, 2))
          0: return enc_r(F7_BASE, any_rs(), any_rs(), 3'($urandom), any_rd(), OP_REG);
          1: return enc_r(F7_ALT, any_rs(), any_rs(), $urandom_range(0, 1) ? F3_SR : F3_ADD,
                          any_rd(), OP_REG);
          default: begin
            case ($urandom_range(0, 3))
              0: f3 = F3_MUL;
              1: f3 = F3_MULH;
              2: f3 = F3_DIV;
              default: f3 = F3_REM;
            endcase
            return enc_r(F7_MULDIV, any_rs(), any_rs(), f3, any_rd(), OP_REG);
          end
        endcase
      end
      2, 3: begin
        f3 = 3'($urandom);
        if (f3 == F3_SLL)
          return enc_r(F7_BASE, 5'($urandom), any_rs(), f3, any_rd(), OP_IMM);
        if (f3 == F3_SR)
          return enc_r($urandom_range(0, 1) ? F7_ALT : F7_BASE, 5'($urandom), any_rs(), f3,
                       any_rd(), OP_IMM);
        return enc_i(12'($urandom), any_rs(), f3, any_rd(), OP_IMM);
      end
      4: begin
        case ($urandom_range(0, 4))
          0: f3 = F3_LB;
          1: f3 = F3_LH;
          2: f3 = F3_LW;
          3: f3 = F3_LBU;
          default: f3 = F3_LHU;
        endcase
        base = $urandom_range(0, 1) ? BASE_REG : 5'd0;
        return enc_i(safe_offset(base), base, f3, any_rd(), OP_LOAD);
      end
      5: begin
        base = $urandom_range(0, 1) ? BASE_REG : 5'd0;
        return enc_s(safe_offset(base), any_rs(), base, 3'($urandom_range(0, 2)));
      end
      6: begin
        case ($urandom_range(0, 5))
          0: f3 = F3_BEQ;
          1: f3 = F3_BNE;
          2: f3 = F3_BLT;
          3: f3 = F3_BGE;
          4: f3 = F3_BLTU;
          default: f3 = F3_BGEU;
        endcase
        return enc_b(13'($urandom), any_rs(), any_rs(), f3);
      end
      7: return $urandom_range(0, 1) ? enc_j(21'($urandom), any_rd())
                                     : enc_i(12'($urandom), any_rs(), 3'd0, any_rd(), OP_JALR);
      default: return {20'($urandom), any_rd(), $urandom_range(0, 1) ? OP_LUI : OP_AUIPC};
    endcase
  endfunction

  // Offer one instruction and hold it until the transfer completes; then
  // either keep the burst going or drop valid for a random gap.
  task automatic issue(input logic [31:0] word);
    s_tdata  <= word;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(0, 6);
      if ($urandom_range(0, 2) != 0) begin
        s_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
      end
    end
  endtask

  // Environment call with a service that keeps the core running.
  task automatic issue_call(input logic [11:0] svc);
    issue(enc_i(svc, 5'd0, F3_ADD, REG_A0, OP_IMM));
    issue(enc_i(12'($urandom), any_rs(), F3_ADD, REG_A1, OP_IMM));
    issue(ECALL_WORD);
  endtask

  // Receiver: switch between free running, random stalls and long stalls.
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 2);
      stall_run  <= $urandom_range(10, 80);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0:       m_tready <= 1'b1;
      1:       m_tready <= $urandom_range(0, 1);
      default: m_tready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  initial begin
    #50_000_000;
    $display("rv32im_instruction_execute: mismatch");
    $finish;
  end

  initial begin
    logic [31:0] w;
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: data pointer, corner values, division corners, memory edges.
    issue({20'd1, BASE_REG, OP_LUI});
    issue(enc_i(12'h800, BASE_REG, F3_ADD, BASE_REG, OP_IMM));       // x5 = 0x800
    issue({20'h80000, 5'd1, OP_LUI});                                  // x1 = min int
    issue(enc_i(12'hfff, 5'd0, F3_ADD, 5'd2, OP_IMM));                 // x2 = -1
    issue(enc_i(12'd1, 5'd0, F3_ADD, 5'd4, OP_IMM));
    issue(enc_i(12'hfff, 5'd1, F3_ADD, 5'd6, OP_IMM));                 // x6 = max int
    issue(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_DIV, 5'd7, OP_REG));        // overflow
    issue(enc_r(F7_MULDIV, 5'd2, 5'd1, F3_REM, 5'd8, OP_REG));
    issue(enc_r(F7_MULDIV, 5'd0, 5'd6, F3_DIV, 5'd9, OP_REG));        // divide by zero
    issue(enc_r(F7_MULDIV, 5'd0, 5'd6, F3_REM, 5'd12, OP_REG));
    issue(enc_r(F7_MULDIV, 5'd1, 5'd1, F3_MULH, 5'd13, OP_REG));
    issue(enc_r(F7_MULDIV, 5'd2, 5'd6, F3_MUL, 5'd14, OP_REG));
    issue(enc_r(F7_ALT, 5'd2, 5'd1, F3_SR, 5'd15, OP_REG));           // shift by 31 only
    issue(enc_r(F7_ALT, 5'd31, 5'd1, F3_SR, 5'd16, OP_IMM));
    issue(enc_i(12'd5, 5'd0, F3_ADD, 5'd0, OP_IMM));                  // x0 stays zero
    issue(enc_r(F7_BASE, 5'd0, 5'd0, F3_ADD, 5'd17, OP_REG));
    issue(enc_s(12'd2044, 5'd1, BASE_REG, F3_LW));                     // last word
    issue(enc_i(12'd2045, BASE_REG, F3_LH, 5'd18, OP_LOAD));          // misaligned
    issue(enc_i(12'd2047, BASE_REG, F3_LB, 5'd19, OP_LOAD));          // last byte
    issue(enc_i(12'd2046, BASE_REG, F3_LHU, 5'd20, OP_LOAD));
    issue(enc_b(13'h1ffc, 5'd6, 5'd1, F3_BLT));                        // backward taken
    issue(enc_j(21'd8, 5'd21));
    issue(enc_i(12'h101, 5'd0, F3_ADD, 5'd22, OP_JALR));              // bit 0 cleared
    issue_call(SVC_PRINT_INT[11:0]);
    issue_call(SVC_PRINT_STR[11:0]);
    issue_call(SVC_PRINT_CHAR[11:0]);

    // Random legal traffic with occasional environment calls.
    for (int n = 0; n < 680; n++) begin
      if (n == 340) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
      end
      if ($urandom_range(0, 40) == 0) begin
        case ($urandom_range(0, 2))
          0:       issue_call(SVC_PRINT_INT[11:0]);
          1:       issue_call(SVC_PRINT_STR[11:0]);
          default: issue_call(SVC_PRINT_CHAR[11:0]);
        endcase
      end else begin
        issue(random_legal());
      end
    end

    // One terminating event, then the core must report halted for anything.
    case ($urandom_range(0, 4))
      0: issue({25'($urandom), 7'h7f});                                  // unknown opcode
      1: issue(enc_i(12'hffc, 5'd0, F3_LW, 5'd7, OP_LOAD));             // address wraps
      2: issue(enc_s(12'd2046, 5'd2, BASE_REG, F3_LW));                  // runs off the end
      3: begin
        issue(enc_i(12'd2, 5'd0, F3_ADD, REG_A0, OP_IMM));              // unknown service
        issue(ECALL_WORD);
      end
      default: begin
        issue(enc_i(SVC_EXIT[11:0], 5'd0, F3_ADD, REG_A0, OP_IMM));
        issue(ECALL_WORD);
      end
    endcase
    for (int n = 0; n < 8; n++) begin
      w = $urandom;
      issue(w);
    end
    issue(32'hffff_ffff);
    issue(32'h0000_0000);
    s_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("rv32im_instruction_execute: match");
    end else begin
      $display("rv32im_instruction_execute: mismatch");
    end
    $finish;
  end

endmodule
